/* hdl/brts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brts_pkg: shared types and constants of the bilinear RGB tile sampler
// Tile geometry, pixel and fixed-point formats, stream layout, register map,
// request kinds and sequencer states.
package brts_pkg;

   // Tile store geometry
   localparam int TILE_DIM    = 256;
   localparam int COORD_BITS  = $clog2(TILE_DIM);
   localparam int DIM_BITS    = COORD_BITS + 1;
   localparam int ADDR_BITS   = 2 * COORD_BITS;
   localparam int STORE_DEPTH = TILE_DIM * TILE_DIM;

   // Pixel format
   localparam int CHAN_BITS = 8;
   localparam int NUM_CHAN  = 3;
   localparam int PIX_BITS  = CHAN_BITS * NUM_CHAN;
   localparam logic [CHAN_BITS-1:0] CHAN_MAX = '1;

   // Sample coordinates, unsigned fixed point
   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 8;
   localparam int INT_BITS    = SAMPLE_BITS - FRAC_BITS;
   localparam int WGT_BITS    = FRAC_BITS + 1;
   localparam int ROW_BITS    = CHAN_BITS + FRAC_BITS;
   localparam int SUM_BITS    = CHAN_BITS + 2 * FRAC_BITS + 1;
   localparam logic [WGT_BITS-1:0] WEIGHT_ONE = WGT_BITS'(1) << FRAC_BITS;

   // Stream payload layout
   localparam int REQ_DATA_BITS = 72;
   localparam int RSP_DATA_BITS = 24;

   // Register map
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic REG_TILE_WIDTH  = 1'b0;
   localparam logic REG_TILE_HEIGHT = 1'b1;
   localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(TILE_DIM);

   // Request kinds
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DRAIN,
      ST_MIX,
      ST_SUM
   } seq_state_type;

endpackage

/* hdl/bilinear_rgb_tile_sampler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_rgb_tile_sampler: RGB888 tile store with bilinear sampling
// Pixel writes fill a single-port tile memory; sample requests fetch four
// neighbors one per cycle and blend each channel in two multiply stages.
// ----------------------------------------------------------------------------
// Write beat: taken in idle, no response; the next beat can enter the cycle after.
// Sample beat: the accept in idle, four serial reads on the single tile memory
// port, a drain state and two blend stages lead to response valid; the next
// beat is taken only once the sum state has loaded the output register.
// A finished sample waits in the output register while the next beat enters.
// Reset clears the sequencer and output valid, and sets both tile dimensions
// to 256; the tile memory is not cleared and reads undefined until written.
// ----------------------------------------------------------------------------
module bilinear_rgb_tile_sampler import brts_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // request stream
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // [7:0] pixel_col, [15:8] pixel_row, [39:16] pixel_rgb,
   // [55:40] sample_x, [71:56] sample_y
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // [0] op
   input  logic                     req_tuser,
   // response stream
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // [7:0] red, [15:8] green, [23:16] blue
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // register port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   // ------------------------------------------------------------------
   // Request fields
   // ------------------------------------------------------------------
   logic [COORD_BITS-1:0]  req_col;
   logic [COORD_BITS-1:0]  req_row;
   logic [PIX_BITS-1:0]    req_rgb;
   logic [SAMPLE_BITS-1:0] req_x;
   logic [SAMPLE_BITS-1:0] req_y;

   assign req_col = req_tdata[7:0];
   assign req_row = req_tdata[15:8];
   assign req_rgb = req_tdata[39:16];
   assign req_x   = req_tdata[55:40];
   assign req_y   = req_tdata[71:56];

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [DIM_BITS-1:0] tile_width_ff;
   logic [DIM_BITS-1:0] tile_height_ff;
   logic                csr_wr;
   logic                csr_sel;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_sel    = csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_width_ff  <= DIM_RESET;
         tile_height_ff <= DIM_RESET;
      end else if (csr_wr) begin
         unique case (csr_sel)
            REG_TILE_WIDTH:  tile_width_ff  <= csr_pwdata[DIM_BITS-1:0];
            REG_TILE_HEIGHT: tile_height_ff <= csr_pwdata[DIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         REG_TILE_WIDTH:  csr_prdata = CSR_DATA_BITS'(tile_width_ff);
         REG_TILE_HEIGHT: csr_prdata = CSR_DATA_BITS'(tile_height_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Neighbor coordinates, clamped to the tile
   // ------------------------------------------------------------------
   logic [COORD_BITS-1:0] w_last;
   logic [COORD_BITS-1:0] h_last;
   logic [COORD_BITS-1:0] x0_c, x1_c, y0_c, y1_c;

   always_comb begin
      // zero acts as one, anything past the store acts as the store size
      if (tile_width_ff == '0)
         w_last = '0;
      else if (tile_width_ff > DIM_RESET)
         w_last = COORD_BITS'(TILE_DIM - 1);
      else
         w_last = COORD_BITS'(tile_width_ff - DIM_BITS'(1));
      if (tile_height_ff == '0)
         h_last = '0;
      else if (tile_height_ff > DIM_RESET)
         h_last = COORD_BITS'(TILE_DIM - 1);
      else
         h_last = COORD_BITS'(tile_height_ff - DIM_BITS'(1));
   end

   always_comb begin
      logic [SAMPLE_BITS-1:0] xi;
      logic [SAMPLE_BITS-1:0] yi;
      xi = SAMPLE_BITS'(req_x >> FRAC_BITS);
      yi = SAMPLE_BITS'(req_y >> FRAC_BITS);
      x0_c = (xi > SAMPLE_BITS'(w_last)) ? w_last : xi[COORD_BITS-1:0];
      y0_c = (yi > SAMPLE_BITS'(h_last)) ? h_last : yi[COORD_BITS-1:0];
      x1_c = (x0_c < w_last) ? x0_c + COORD_BITS'(1) : w_last;
      y1_c = (y0_c < h_last) ? y0_c + COORD_BITS'(1) : h_last;
   end

   // ------------------------------------------------------------------
   // Sample context
   // ------------------------------------------------------------------
   logic [COORD_BITS-1:0] x0_ff, x1_ff, y0_ff, y1_ff;
   logic [FRAC_BITS-1:0]  tx_ff, ty_ff;
   logic [1:0]            cnt_ff, cnt_in;
   seq_state_type         state_ff, state_in;

   logic req_acc;
   logic take_sample;
   logic mem_we;
   logic pix_shift;
   logic mix_en;
   logic out_load;
   logic out_free;

   assign req_acc     = req_tvalid & req_tready;
   assign take_sample = req_acc & (req_tuser == OP_SAMPLE);
   assign out_free    = ~rsp_tvalid | rsp_tready;

   always_ff @(posedge clock) begin
      if (take_sample) begin
         x0_ff <= x0_c;
         x1_ff <= x1_c;
         y0_ff <= y0_c;
         y1_ff <= y1_c;
         tx_ff <= req_x[FRAC_BITS-1:0];
         ty_ff <= req_y[FRAC_BITS-1:0];
      end
   end

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (take_sample) state_in = ST_FETCH;
         ST_FETCH: if (cnt_ff == 2'd3) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_MIX;
         ST_MIX:   state_in = ST_SUM;
         ST_SUM:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      mem_we     = 1'b0;
      pix_shift  = 1'b0;
      mix_en     = 1'b0;
      out_load   = 1'b0;
      cnt_in     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            mem_we     = req_tvalid & (req_tuser == OP_WRITE);
         end
         ST_FETCH: begin
            cnt_in    = cnt_ff + 2'd1;
            pix_shift = (cnt_ff != 2'd0);
         end
         ST_DRAIN: pix_shift = 1'b1;
         ST_MIX:   mix_en    = 1'b1;
         ST_SUM:   out_load  = out_free;
         default: ;
      endcase
   end

   // ------------------------------------------------------------------
   // Tile memory: one port, registered read
   // ------------------------------------------------------------------
   logic [PIX_BITS-1:0]  store_mem [STORE_DEPTH];
   logic [PIX_BITS-1:0]  rd_data_ff;
   logic [ADDR_BITS-1:0] mem_addr;

   always_comb begin
      mem_addr = {req_row, req_col};
      if (state_ff == ST_FETCH) begin
         case (cnt_ff)
            2'd0:    mem_addr = {y0_ff, x0_ff};
            2'd1:    mem_addr = {y0_ff, x1_ff};
            2'd2:    mem_addr = {y1_ff, x0_ff};
            default: mem_addr = {y1_ff, x1_ff};
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we)
         store_mem[mem_addr] <= req_rgb;
      rd_data_ff <= store_mem[mem_addr];
   end

   // Shift the four neighbors in: c00, c10, c01, c11 end in slots 0..3
   logic [PIX_BITS-1:0] pix_ff [4];

   always_ff @(posedge clock) begin
      if (pix_shift) begin
         pix_ff[0] <= pix_ff[1];
         pix_ff[1] <= pix_ff[2];
         pix_ff[2] <= pix_ff[3];
         pix_ff[3] <= rd_data_ff;
      end
   end

   // ------------------------------------------------------------------
   // Blend: horizontal pass, then vertical pass
   // ------------------------------------------------------------------
   logic [WGT_BITS-1:0]  wx0, wy0;
   logic [ROW_BITS-1:0]  top_ff [NUM_CHAN];
   logic [ROW_BITS-1:0]  bot_ff [NUM_CHAN];
   logic [CHAN_BITS-1:0] chan_res [NUM_CHAN];

   assign wx0 = WEIGHT_ONE - WGT_BITS'(tx_ff);
   assign wy0 = WEIGHT_ONE - WGT_BITS'(ty_ff);

   always_ff @(posedge clock) begin
      if (mix_en) begin
         for (int ch = 0; ch < NUM_CHAN; ch++) begin
            top_ff[ch] <=
               ROW_BITS'(pix_ff[0][PIX_BITS-1-CHAN_BITS*ch -: CHAN_BITS]) * ROW_BITS'(wx0) +
               ROW_BITS'(pix_ff[1][PIX_BITS-1-CHAN_BITS*ch -: CHAN_BITS]) * ROW_BITS'(tx_ff);
            bot_ff[ch] <=
               ROW_BITS'(pix_ff[2][PIX_BITS-1-CHAN_BITS*ch -: CHAN_BITS]) * ROW_BITS'(wx0) +
               ROW_BITS'(pix_ff[3][PIX_BITS-1-CHAN_BITS*ch -: CHAN_BITS]) * ROW_BITS'(tx_ff);
         end
      end
   end

   always_comb begin
      logic [SUM_BITS-1:0]  acc;
      logic [SUM_BITS-1:0]  whole;
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         acc   = SUM_BITS'(top_ff[ch]) * SUM_BITS'(wy0) +
                 SUM_BITS'(bot_ff[ch]) * SUM_BITS'(ty_ff);
         whole = acc >> (2 * FRAC_BITS);
         // saturate to the channel range
         chan_res[ch] = (whole > SUM_BITS'(CHAN_MAX)) ? CHAN_MAX
                                                      : whole[CHAN_BITS-1:0];
      end
   end

   // ------------------------------------------------------------------
   // Response register
   // ------------------------------------------------------------------
   logic                     rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff;

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (rsp_tready)
         rsp_tvalid_in = 1'b0;
      if (out_load)
         rsp_tvalid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_tvalid_ff <= 1'b0;
      else
         rsp_tvalid_ff <= rsp_tvalid_in;
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         for (int ch = 0; ch < NUM_CHAN; ch++)
            rsp_data_ff[CHAN_BITS*ch +: CHAN_BITS] <= chan_res[ch];
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_sample_starts_fetch: assert property (@(posedge clock) disable iff (reset)
      take_sample |=> (state_ff == ST_FETCH) && (cnt_ff == 2'd0))
      else $error("sample beat did not start the neighbor fetch");

   a_write_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_tuser == OP_WRITE) |=> state_ff == ST_IDLE)
      else $error("pixel write left the idle state");

   a_no_write_during_fetch: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_IDLE) && req_acc)
      else $error("tile memory written outside an accepted write beat");

   a_rsp_from_sum: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == ST_SUM))
      else $error("response raised without a finished blend");

   a_fetch_leads_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH && cnt_ff == 2'd3) |=> state_ff == ST_DRAIN)
      else $error("fetch did not end after four reads");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the bilinear RGB tile sampler
// Streams pixel writes and sample requests through the request port under
// random backpressure, re-computes every sample from a local copy of the tile
// and the tile size registers, and compares each response beat channel by
// channel. Tile size is reprogrammed over the APB-style port between phases.
// ----------------------------------------------------------------------------
module tb;
   import brts_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int HOLD_CYCLES = 240;
   localparam int DRAIN_CYCLES = 16;
   localparam int SEG_COUNT = 8;
   localparam int SEG_BEATS = 55;

   typedef struct packed {
      logic                   op;
      logic [COORD_BITS-1:0]  col;
      logic [COORD_BITS-1:0]  row;
      logic [PIX_BITS-1:0]    rgb;
      logic [SAMPLE_BITS-1:0] sx;
      logic [SAMPLE_BITS-1:0] sy;
   } req_beat_type;

   typedef struct packed {
      logic [CHAN_BITS-1:0] red;
      logic [CHAN_BITS-1:0] green;
      logic [CHAN_BITS-1:0] blue;
   } rgb_sample_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   // [7:0] pixel_col, [15:8] pixel_row, [39:16] pixel_rgb,
   // [55:40] sample_x, [71:56] sample_y
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   // [0] op
   logic                     req_tuser = OP_WRITE;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // [7:0] red, [15:8] green, [23:16] blue
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   // tile size as the block sees it, updated at each register write
   logic [DIM_BITS-1:0] cfg_width = DIM_RESET;
   logic [DIM_BITS-1:0] cfg_height = DIM_RESET;

   // pixel contents as of the last accepted beat
   logic [PIX_BITS-1:0] tile_mem [STORE_DEPTH];
   // pixels the stimulus has already scheduled a write for
   bit                  pix_written [STORE_DEPTH];

   req_beat_type   pending_beats[$];
   rgb_sample_type expected_pixels[$];
   req_beat_type   beat_on_bus;

   int send_idle_pct = 24;
   int recv_idle_pct = 50;
   bit hold_start = 1'b0;
   bit hold_taken = 1'b0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int err_count = 0;
   int seg_items = 0;
   int writes_done = 0;
   int samples_done = 0;
   int results_seen = 0;

   bilinear_rgb_tile_sampler u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // zero acts as one column, anything past the store acts as the full store
   function automatic int unsigned tile_extent(input logic [DIM_BITS-1:0] dim);
      if (dim == 0) return 1;
      if (dim > TILE_DIM) return TILE_DIM;
      return dim;
   endfunction

   function automatic void neighbor_pair(input int unsigned pos, input int unsigned extent,
                                         output int unsigned c0, output int unsigned c1);
      c0 = (pos > extent - 1) ? extent - 1 : pos;
      c1 = (c0 + 1 < extent - 1) ? c0 + 1 : extent - 1;
   endfunction

   function automatic logic [CHAN_BITS-1:0] blend_channel(
         input logic [CHAN_BITS-1:0] c00, input logic [CHAN_BITS-1:0] c10,
         input logic [CHAN_BITS-1:0] c01, input logic [CHAN_BITS-1:0] c11,
         input longint unsigned tx, input longint unsigned ty);
      longint unsigned one, top, bot, acc;
      one = longint'(1) << FRAC_BITS;
      top = c00 * (one - tx) + c10 * tx;
      bot = c01 * (one - tx) + c11 * tx;
      acc = (top * (one - ty) + bot * ty) >> (2 * FRAC_BITS);
      return (acc > CHAN_MAX) ? CHAN_MAX : acc[CHAN_BITS-1:0];
   endfunction

   function automatic rgb_sample_type bilinear_sample(input logic [SAMPLE_BITS-1:0] sx,
                                                      input logic [SAMPLE_BITS-1:0] sy);
      int unsigned x0, x1, y0, y1;
      longint unsigned tx, ty;
      logic [PIX_BITS-1:0] p00, p10, p01, p11;
      rgb_sample_type res;
      neighbor_pair(sx >> FRAC_BITS, tile_extent(cfg_width), x0, x1);
      neighbor_pair(sy >> FRAC_BITS, tile_extent(cfg_height), y0, y1);
      tx = sx[FRAC_BITS-1:0];
      ty = sy[FRAC_BITS-1:0];
      p00 = tile_mem[y0 * TILE_DIM + x0];
      p10 = tile_mem[y0 * TILE_DIM + x1];
      p01 = tile_mem[y1 * TILE_DIM + x0];
      p11 = tile_mem[y1 * TILE_DIM + x1];
      res.red   = blend_channel(p00[23:16], p10[23:16], p01[23:16], p11[23:16], tx, ty);
      res.green = blend_channel(p00[15:8], p10[15:8], p01[15:8], p11[15:8], tx, ty);
      res.blue  = blend_channel(p00[7:0], p10[7:0], p01[7:0], p11[7:0], tx, ty);
      return res;
   endfunction

   task automatic queue_write(input logic [COORD_BITS-1:0] col,
                              input logic [COORD_BITS-1:0] row,
                              input logic [PIX_BITS-1:0] rgb);
      req_beat_type b;
      b.op  = OP_WRITE;
      b.col = col;
      b.row = row;
      b.rgb = rgb;
      b.sx  = SAMPLE_BITS'($urandom_range(0, 65535));
      b.sy  = SAMPLE_BITS'($urandom_range(0, 65535));
      pending_beats.push_back(b);
      pix_written[{row, col}] = 1'b1;
      seg_items++;
   endtask

   task automatic cover_pixel(input int unsigned col, input int unsigned row);
      if (!pix_written[row * TILE_DIM + col])
         queue_write(COORD_BITS'(col), COORD_BITS'(row),
                     PIX_BITS'($urandom_range(0, 24'hFFFFFF)));
   endtask

   // schedule writes for any neighbor not yet scheduled for a write, then the sample itself
   task automatic queue_sample(input logic [SAMPLE_BITS-1:0] sx,
                               input logic [SAMPLE_BITS-1:0] sy);
      int unsigned x0, x1, y0, y1;
      req_beat_type b;
      neighbor_pair(sx >> FRAC_BITS, tile_extent(cfg_width), x0, x1);
      neighbor_pair(sy >> FRAC_BITS, tile_extent(cfg_height), y0, y1);
      cover_pixel(x0, y0);
      cover_pixel(x1, y0);
      cover_pixel(x0, y1);
      cover_pixel(x1, y1);
      b.op  = OP_SAMPLE;
      b.col = COORD_BITS'($urandom_range(0, 255));
      b.row = COORD_BITS'($urandom_range(0, 255));
      b.rgb = PIX_BITS'($urandom_range(0, 24'hFFFFFF));
      b.sx  = sx;
      b.sy  = sy;
      pending_beats.push_back(b);
      seg_items++;
   endtask

   task automatic wait_idle();
      while (pending_beats.size() != 0 || req_tvalid || expected_pixels.size() != 0)
         @(posedge clock);
      // write beats give no response, so leave room for one still in flight
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [DIM_BITS-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_BITS'({idx, 2'b00});
      csr_pwdata  <= CSR_DATA_BITS'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == REG_TILE_WIDTH) cfg_width = value;
      else cfg_height = value;
   endtask

   // update the tile copy or predict the response for the beat just taken
   task automatic absorb_beat(input req_beat_type b);
      if (b.op == OP_WRITE) begin
         tile_mem[{b.row, b.col}] = b.rgb;
         writes_done++;
      end else begin
         expected_pixels.push_back(bilinear_sample(b.sx, b.sy));
         samples_done++;
      end
   endtask

   always @(posedge clock) begin : drive_requests
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            absorb_beat(beat_on_bus);
         if (!req_tvalid || req_tready) begin
            if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               beat_on_bus = pending_beats.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= beat_on_bus.op;
               req_tdata  <= {beat_on_bus.sy, beat_on_bus.sx, beat_on_bus.rgb,
                              beat_on_bus.row, beat_on_bus.col};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_responses
      rgb_sample_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.red   = rsp_tdata[7:0];
            got.green = rsp_tdata[15:8];
            got.blue  = rsp_tdata[23:16];
            results_seen++;
            if (expected_pixels.size() == 0) begin
               $error("response beat with no sample outstanding: %h", rsp_tdata);
               err_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (got.red !== want.red) begin
                  $error("red: expected %0d, actual %0d", want.red, got.red);
                  err_count++;
               end
               if (got.green !== want.green) begin
                  $error("green: expected %0d, actual %0d", want.green, got.green);
                  err_count++;
               end
               if (got.blue !== want.blue) begin
                  $error("blue: expected %0d, actual %0d", want.blue, got.blue);
                  err_count++;
               end
            end
         end
         if (hold_start && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         // hold ready low so the output register fills and the input backs up
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int unsigned seg_w [SEG_COUNT];
      int unsigned seg_h [SEG_COUNT];
      int unsigned ext_w, ext_h;
      logic [SAMPLE_BITS-1:0] sx, sy;

      seg_w = '{256, 1, 0, 256, 3, 511, 17, 256};
      seg_h = '{256, 1, 511, 1, 5, 0, 200, 256};

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // corners, fraction extremes and the far edge of the store
      queue_write(8'd0, 8'd0, 24'h000000);
      queue_write(8'd1, 8'd0, 24'hFFFFFF);
      queue_write(8'd0, 8'd1, 24'hFF00FF);
      queue_write(8'd1, 8'd1, 24'h00FF00);
      queue_sample(16'h0000, 16'h0000);
      queue_sample(16'h00FF, 16'h0000);
      queue_sample(16'h0000, 16'h00FF);
      queue_sample(16'h00FF, 16'h00FF);
      queue_sample(16'h0080, 16'h0080);
      queue_sample(16'h00FF, 16'h0001);
      queue_write(8'd255, 8'd255, 24'hFFFFFF);
      queue_sample(16'hFFFF, 16'hFFFF);
      queue_sample(16'hFF80, 16'hFF00);
      queue_sample(16'hFF80, 16'h00FF);
      queue_sample(16'h0180, 16'hFE40);

      for (int seg = 0; seg < SEG_COUNT; seg++) begin
         if (seg != 0) begin
            wait_idle();
            csr_write(REG_TILE_WIDTH, DIM_BITS'(seg_w[seg]));
            csr_write(REG_TILE_HEIGHT, DIM_BITS'(seg_h[seg]));
         end
         if (seg < 3) begin
            send_idle_pct = 24;
            recv_idle_pct = 50;
         end else if (seg < 6) begin
            send_idle_pct = 50;
            recv_idle_pct = 24;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         ext_w = tile_extent(cfg_width);
         ext_h = tile_extent(cfg_height);
         seg_items = 0;
         while (seg_items < SEG_BEATS) begin
            if ($urandom_range(0, 99) < 25) begin
               queue_write(COORD_BITS'($urandom_range(0, 255)),
                           COORD_BITS'($urandom_range(0, 255)),
                           PIX_BITS'($urandom_range(0, 24'hFFFFFF)));
            end else begin
               if ($urandom_range(0, 99) < 80) begin
                  sx = SAMPLE_BITS'($urandom_range(0, ext_w * 256 - 1));
                  sy = SAMPLE_BITS'($urandom_range(0, ext_h * 256 - 1));
               end else begin
                  sx = SAMPLE_BITS'($urandom_range(0, 65535));
                  sy = SAMPLE_BITS'($urandom_range(0, 65535));
               end
               queue_sample(sx, sy);
            end
         end
         if (seg == 6)
            hold_start = 1'b1;
      end

      wait_idle();
      if (expected_pixels.size() != 0) begin
         $error("%0d samples never answered", expected_pixels.size());
         err_count++;
      end
      $display("Run covered %0d pixel writes and %0d samples (%0d responses checked)",
               writes_done, samples_done, results_seen);
      $display("over %0d tile size settings including zero and oversized registers",
               SEG_COUNT);
      if (err_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/brts_pkg.sv
hdl/bilinear_rgb_tile_sampler.sv
tb/tb.sv
